// ===== src/lzsd_pkg.sv =====
// ----------------------------------------------------------------------------
// LZSS decoder package
// Shared constants and transfer types for the LZSS byte stream decoder.
// ----------------------------------------------------------------------------
package lzsd_pkg;

    localparam int WINDOW_DEPTH = 4096;
    localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = 32;
    localparam int LEN_W        = 5;
    localparam int BITS_W       = 4;

    localparam logic [3:0]        LEN_MASK        = 4'hF;
    localparam logic [LEN_W-1:0]  LEN_BIAS        = LEN_W'(2);
    localparam logic [BITS_W-1:0] TOKENS_PER_FLAG = BITS_W'(8);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_start;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       done_res;
        logic       bad_offset;
    } t_out_item;

    // history window access: one write and one read per cycle
    typedef struct packed {
        logic              we;
        logic [WIN_AW-1:0] waddr;
        logic [7:0]        wdata;
        logic [WIN_AW-1:0] raddr;
    } t_hist_req;

endpackage

// ===== src/lzss_byte_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// LZSS byte stream decoder
// Decodes a 12-bit-offset / 4-bit-length LZSS stream, one byte in per transfer.
// ----------------------------------------------------------------------------
// Order: an input byte is captured in S_IDLE and decoded in S_EXEC; a literal
//   goes from there to the output register, while a back-reference moves to
//   S_COPY, which writes one copied byte per cycle to the output register while
//   the output is not stalled, with one history read per cycle. A new input byte
//   is taken only once the decoder is back in S_IDLE; output stalls hold it up.
// Reset (synchronous, active low): decoder idle, output empty, stream state and
//   output_length cleared; history contents are not cleared.
// ----------------------------------------------------------------------------
module lzss_byte_stream_decoder (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // compressed byte input
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  lzsd_pkg::t_in_item          i_in,
    // decompressed byte output
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output lzsd_pkg::t_out_item         o_out,
    // output_length register
    input  logic                        i_cfg_we,
    input  logic [lzsd_pkg::CNT_W-1:0]  i_cfg_data
);
    import lzsd_pkg::*;

    logic [CNT_W-1:0] r_output_length;
    t_hist_req        hist_req;
    logic [7:0]       hist_rdata;

    // Configuration register; the user must write it only while the decoder is idle (not enforced here).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_output_length <= '0;
        end else if (i_cfg_we) begin
            r_output_length <= i_cfg_data;
        end
    end

    // Token parsing, copy sequencing and output register. The input is
    // captured on the transfer so the output side may stall independently.
    lzsd_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_in            (i_in),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out           (o_out),
        .i_output_length (r_output_length),
        .o_hist_req      (hist_req),
        .i_hist_rdata    (hist_rdata)
    );

    // 4 KiB sliding window. Every decoded byte is written here (error results are not);
    // copies read one entry ahead, and an offset-of-one copy forwards its previous byte.
    lzsd_history u_history (
        .i_clk   (i_clk),
        .i_req   (hist_req),
        .o_rdata (hist_rdata)
    );

    // A history write only happens when the output register can take the byte.
    a_write_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hist_req.we |-> (!o_out_valid || i_out_ready))
        else $error("history write while output register is occupied");

    // Every history write is paired with a good (non-error) result.
    a_write_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hist_req.we |=> (o_out_valid && !o_out.bad_offset
                         && o_out.out_byte == $past(hist_req.wdata)))
        else $error("history write without matching output byte");

    // The decoder does not accept input in the cycle after an input transfer.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while still processing");

    // No history write in the cycle an input byte is taken.
    a_no_write_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> !hist_req.we)
        else $error("history write during input transfer");

endmodule

// ===== src/lzsd_history.sv =====
// ----------------------------------------------------------------------------
// LZSS history window
// Single-port-write, single-port-read byte memory, read data registered.
// ----------------------------------------------------------------------------
module lzsd_history (
    input  logic                i_clk,
    input  lzsd_pkg::t_hist_req i_req,
    output logic [7:0]          o_rdata
);
    import lzsd_pkg::*;

    logic [7:0] r_mem [WINDOW_DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/lzsd_ctrl.sv =====
// ----------------------------------------------------------------------------
// LZSS token decoder and copy sequencer
// Parses flag/literal/pair bytes, runs back-references one byte per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module lzsd_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  lzsd_pkg::t_in_item           i_in,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output lzsd_pkg::t_out_item          o_out,
    input  logic [lzsd_pkg::CNT_W-1:0]   i_output_length,
    output lzsd_pkg::t_hist_req          o_hist_req,
    input  logic [7:0]                   i_hist_rdata
);
    import lzsd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_COPY
    } t_state;

    t_state            r_state, n_state;
    t_in_item          r_in, n_in;
    t_out_item         r_out, n_out;
    logic              r_out_valid, n_out_valid;
    logic [WIN_AW-1:0] r_wp, n_wp;
    logic [CNT_W-1:0]  r_prod, n_prod;
    logic [7:0]        r_flag, n_flag;
    logic [BITS_W-1:0] r_bits, n_bits;
    logic [7:0]        r_pair_low, n_pair_low;
    logic              r_pend, n_pend;
    logic              r_fin, n_fin;
    logic [WIN_AW-1:0] r_src, n_src;
    logic [LEN_W-1:0]  r_remain, n_remain;
    logic              r_off1, n_off1;
    logic              r_first, n_first;
    logic [7:0]        r_prev, n_prev;

    t_hist_req         hist_req;

    // state as seen after an optional stream restart
    logic [WIN_AW-1:0] e_wp;
    logic [CNT_W-1:0]  e_prod;
    logic [BITS_W-1:0] e_bits;
    logic              e_pend;
    logic              e_fin;

    logic              slot;
    logic [15:0]       word;
    logic [WIN_AW-1:0] offset;
    logic [LEN_W-1:0]  copy_len;
    logic              bad;
    logic [CNT_W-1:0]  prod_inc;
    logic              done;
    logic [7:0]        copy_byte;
    logic              copy_end;

    always_comb begin
        e_wp   = r_in.stream_start ? '0 : r_wp;
        e_prod = r_in.stream_start ? '0 : r_prod;
        e_bits = r_in.stream_start ? '0 : r_bits;
        e_pend = r_in.stream_start ? 1'b0 : r_pend;
        e_fin  = r_in.stream_start ? 1'b0 : r_fin;

        slot     = !r_out_valid || i_out_ready;
        word     = {r_in.in_byte, r_pair_low};
        offset   = word[15:4];
        copy_len = {1'b0, word[3:0] & LEN_MASK} + LEN_BIAS;
        bad      = (offset == '0) || ({{(CNT_W-WIN_AW){1'b0}}, offset} > e_prod);

        copy_byte = (r_off1 && !r_first) ? r_prev : i_hist_rdata;
        copy_end  = 1'b0;
        prod_inc  = '0;
        done      = 1'b0;

        n_state     = r_state;
        n_in        = r_in;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        n_wp        = r_wp;
        n_prod      = r_prod;
        n_flag      = r_flag;
        n_bits      = r_bits;
        n_pair_low  = r_pair_low;
        n_pend      = r_pend;
        n_fin       = r_fin;
        n_src       = r_src;
        n_remain    = r_remain;
        n_off1      = r_off1;
        n_first     = r_first;
        n_prev      = r_prev;
        hist_req    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in    = i_in;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_wp   = e_wp;
                n_prod = e_prod;
                n_bits = e_bits;
                n_pend = e_pend;
                n_fin  = e_fin;
                prod_inc = e_prod + CNT_W'(1);
                done     = (prod_inc == i_output_length);
                priority if (e_fin || (e_prod >= i_output_length)) begin
                    n_fin   = 1'b1;
                    n_state = S_IDLE;
                end else if (e_bits == '0) begin
                    n_flag  = r_in.in_byte;
                    n_bits  = TOKENS_PER_FLAG;
                    n_state = S_IDLE;
                end else if (r_flag[0]) begin
                    // literal: hold until the output register is free
                    if (slot) begin
                        hist_req.we    = 1'b1;
                        hist_req.waddr = e_wp;
                        hist_req.wdata = r_in.in_byte;
                        n_wp        = e_wp + WIN_AW'(1);
                        n_prod      = prod_inc;
                        n_fin       = done;
                        n_flag      = r_flag >> 1;
                        n_bits      = e_bits - BITS_W'(1);
                        n_out       = '{out_byte: r_in.in_byte, last: 1'b1,
                                        done_res: done, bad_offset: 1'b0};
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else if (!e_pend) begin
                    n_pair_low = r_in.in_byte;
                    n_pend     = 1'b1;
                    n_state    = S_IDLE;
                end else if (bad) begin
                    if (slot) begin
                        n_pend      = 1'b0;
                        n_flag      = r_flag >> 1;
                        n_bits      = e_bits - BITS_W'(1);
                        n_out       = '{out_byte: 8'h00, last: 1'b1,
                                        done_res: 1'b0, bad_offset: 1'b1};
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else begin
                    n_pend   = 1'b0;
                    n_flag   = r_flag >> 1;
                    n_bits   = e_bits - BITS_W'(1);
                    n_src    = e_wp - offset;
                    n_off1   = (offset == WIN_AW'(1));
                    n_remain = copy_len;
                    n_first  = 1'b1;
                    n_state  = S_COPY;
                end
            end
            S_COPY: begin
                if (slot) begin
                    prod_inc = r_prod + CNT_W'(1);
                    done     = (prod_inc == i_output_length);
                    copy_end = done || (r_remain == LEN_W'(1));
                    hist_req.we    = 1'b1;
                    hist_req.waddr = r_wp;
                    hist_req.wdata = copy_byte;
                    n_wp        = r_wp + WIN_AW'(1);
                    n_prod      = prod_inc;
                    n_fin       = done;
                    n_src       = r_src + WIN_AW'(1);
                    n_remain    = r_remain - LEN_W'(1);
                    n_first     = 1'b0;
                    n_prev      = copy_byte;
                    n_out       = '{out_byte: copy_byte, last: copy_end,
                                    done_res: done, bad_offset: 1'b0};
                    n_out_valid = 1'b1;
                    if (copy_end) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // read address leads by one: data for the next source arrives next cycle
        hist_req.raddr = n_src;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_wp        <= '0;
            r_prod      <= '0;
            r_flag      <= '0;
            r_bits      <= '0;
            r_pair_low  <= '0;
            r_pend      <= 1'b0;
            r_fin       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_wp        <= n_wp;
            r_prod      <= n_prod;
            r_flag      <= n_flag;
            r_bits      <= n_bits;
            r_pair_low  <= n_pair_low;
            r_pend      <= n_pend;
            r_fin       <= n_fin;
        end
        r_in     <= n_in;
        r_out    <= n_out;
        r_src    <= n_src;
        r_remain <= n_remain;
        r_off1   <= n_off1;
        r_first  <= n_first;
        r_prev   <= n_prev;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_hist_req  = hist_req;

endmodule

// ===== bench/lzss_byte_stream_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// LZSS byte stream decoder testbench
// Feeds compressed byte streams: a short hand-built set, then random streams
// with noise and broken token groups. Each output transfer is checked in
// order against an in-bench model of the decoder; output_length is changed
// between phases while the block is idle. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module lzss_byte_stream_decoder_tb;
    import lzsd_pkg::*;

    localparam int ITEM_TARGET  = 340;      // input transfers, queued or taken
    localparam int MAX_PHASES   = 60;
    localparam int DRAIN_CYCLES = 24;       // room for the longest copy, 17 bytes
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int LONG_HOLD    = 300;

    typedef enum int {RX_STEADY, RX_COIN, RX_EVERY4, RX_SPARSE} t_rx_mode;

    // ------------------------------------------------------------------------
    // Decoder model and expected-byte store
    // ------------------------------------------------------------------------
    class lzss_scoreboard;
        logic [7:0]        window [WINDOW_DEPTH];
        logic [WIN_AW-1:0] wr_ptr;
        logic [CNT_W-1:0]  out_count;
        logic [CNT_W-1:0]  length_limit;
        logic [7:0]        flags;
        logic [BITS_W-1:0] tokens_left;
        logic [7:0]        pair_lo;
        bit                pair_wait;
        bit                stream_done;
        t_out_item         expected_q[$];
        int                errors;

        function new();
            restart();
            length_limit = '0;
            errors       = 0;
        endfunction

        function void restart();
            wr_ptr      = '0;
            out_count   = '0;
            flags       = '0;
            tokens_left = '0;
            pair_lo     = '0;
            pair_wait   = 0;
            stream_done = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // writes one byte to the window and queues it; 1 when output completes
        function bit put_byte(logic [7:0] b);
            t_out_item r;
            window[wr_ptr] = b;
            wr_ptr++;
            out_count++;
            r.out_byte   = b;
            r.last       = 1'b0;
            r.done_res   = (out_count == length_limit);
            r.bad_offset = 1'b0;
            if (r.done_res)
                stream_done = 1;
            expected_q = {expected_q, r};
            return r.done_res;
        endfunction

        // returns 1 when the byte was decoded, 0 when the decoder ignores it
        function bit note_input(t_in_item it);
            logic [15:0]       word;
            logic [11:0]       offset;
            logic [WIN_AW-1:0] src;
            int                copy_len;
            int                first;
            t_out_item         r;
            first = expected_q.size();
            if (it.stream_start)
                restart();
            if (!stream_done && out_count >= length_limit)
                stream_done = 1;
            if (stream_done)
                return 0;
            if (tokens_left == 0) begin
                flags       = it.in_byte;
                tokens_left = TOKENS_PER_FLAG;
                return 1;
            end
            if (flags[0]) begin
                flags = flags >> 1;
                tokens_left--;
                void'(put_byte(it.in_byte));
            end else if (!pair_wait) begin
                pair_lo   = it.in_byte;
                pair_wait = 1;
                return 1;
            end else begin
                word      = {it.in_byte, pair_lo};
                offset    = word[15:4];
                copy_len  = int'(word[3:0] & LEN_MASK) + int'(LEN_BIAS);
                pair_wait = 0;
                flags     = flags >> 1;
                tokens_left--;
                if (offset == 0 || CNT_W'(offset) > out_count) begin
                    r.out_byte   = 8'h00;
                    r.last       = 1'b0;
                    r.done_res   = 1'b0;
                    r.bad_offset = 1'b1;
                    expected_q = {expected_q, r};
                end else begin
                    for (int i = 0; i < copy_len; i++) begin
                        src = wr_ptr - offset;
                        if (put_byte(window[src]))
                            break;
                    end
                end
            end
            if (expected_q.size() > first) begin
                r = expected_q.pop_back();
                r.last = 1'b1;
                expected_q = {expected_q, r};
            end
            return 1;
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_q.size() == 0) begin
                $error("unexpected output transfer: out_byte %0h", got.out_byte);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("out_byte", want.out_byte, got.out_byte);
            compare_field("last", 8'(want.last), 8'(got.last));
            compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
            compare_field("bad_offset", 8'(want.bad_offset), 8'(got.bad_offset));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------------
    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    t_in_item         in_data;
    logic             out_valid;
    logic             out_ready;
    t_out_item        out_data;
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_data;

    always #4 clk = ~clk;

    lzss_byte_stream_decoder u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    lzss_scoreboard sb;
    t_in_item       stim_q[$];     // bytes waiting to be offered
    int             live_items   = 0;
    int             results_seen = 0;
    int             cycle_count  = 0;

    // ------------------------------------------------------------------------
    // Input side: bursts of random length with random gaps. A gap is only
    // taken once the current transfer has gone, so valid never drops early.
    // ------------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                void'(sb.note_input(in_data));
                live_items++;
            end
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (stim_q.size() > 0) begin
                    in_data  <= stim_q.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 16);
                        // a quarter of bursts run straight into the next one
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output side: ready follows a mode that is redrawn at random intervals.
    // Once, while the sender still has plenty queued, ready is held low for a
    // long stretch so the output path backs up into the input handshake.
    // ------------------------------------------------------------------------
    t_rx_mode rx_mode    = RX_STEADY;
    int       mode_left  = 0;
    int       rx_tick    = 0;
    int       hold_left  = 0;
    bit       held_once  = 0;

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                sb.check_result(out_data);
                results_seen++;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (!held_once && results_seen >= 60 && stim_q.size() >= 10) begin
                held_once = 1;
                hold_left = LONG_HOLD;
                out_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode_left = $urandom_range(20, 120);
                    rx_mode   = t_rx_mode'($urandom_range(0, 3));
                end
                mode_left--;
                rx_tick++;
                case (rx_mode)
                    RX_STEADY: out_ready <= 1'b1;
                    RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
                    RX_EVERY4: out_ready <= (rx_tick % 4 == 0);
                    default:   out_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus generation
    // gen_count tracks how many bytes the stream being built has produced, so
    // that copy offsets can be aimed at the valid range or just past it.
    // ------------------------------------------------------------------------
    int gen_count   = 0;
    bit gen_aligned = 1;   // stream sits on a flag-byte boundary

    function void queue_byte(logic [7:0] b, logic s);
        t_in_item it;
        it.in_byte      = b;
        it.stream_start = s;
        stim_q = {stim_q, it};
    endfunction

    function automatic logic [15:0] copy_word();
        logic [11:0] offset;
        logic [3:0]  len_code;
        int          r;
        int          max_off;
        r        = $urandom_range(0, 99);
        len_code = $urandom_range(0, 1) ? LEN_MASK : 4'($urandom);
        max_off  = (gen_count < WINDOW_DEPTH - 1) ? gen_count : WINDOW_DEPTH - 1;
        if (r < 8 || max_off == 0) begin
            // zero offset, or one reaching before the stream start
            if ($urandom_range(0, 1) == 0 || gen_count >= WINDOW_DEPTH - 1)
                offset = '0;
            else
                offset = 12'($urandom_range(gen_count + 1, WINDOW_DEPTH - 1));
        end else begin
            if (r < 40)
                offset = 12'($urandom_range(1, (max_off < 4) ? max_off : 4));  // overlap
            else if (r < 55)
                offset = 12'(max_off);                                        // farthest
            else
                offset = 12'($urandom_range(1, max_off));
            gen_count += int'(len_code) + int'(LEN_BIAS);
        end
        return {offset, len_code};
    endfunction

    // one flag byte and its eight tokens; a broken group loses its tail
    function automatic void gen_group(bit opens, bit broken);
        logic [7:0]  flag;
        logic [15:0] word;
        int          pushed;
        flag   = 8'($urandom);
        pushed = 1;
        queue_byte(flag, opens);
        for (int t = 0; t < int'(TOKENS_PER_FLAG); t++) begin
            if (flag[t]) begin
                queue_byte(8'($urandom), 1'b0);
                gen_count++;
                pushed++;
            end else begin
                word = copy_word();
                queue_byte(word[7:0], 1'b0);
                queue_byte(word[15:8], 1'b0);
                pushed += 2;
            end
        end
        if (broken) begin
            repeat ($urandom_range(1, pushed - 1))
                void'(stim_q.pop_back());
            gen_aligned = 0;
        end
    endfunction

    // all stimulus taken, every expected byte seen, pipeline drained
    task automatic wait_idle();
        do @(negedge clk);
        while (stim_q.size() != 0 || in_valid || sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_output_length(logic [CNT_W-1:0] v);
        wait_idle();
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        sb.length_limit = v;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int               r;
        int               n_groups;
        bit               fresh;
        bit               broken;
        logic [CNT_W-1:0] out_len;

        sb       = new();
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        out_ready = 1'b0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: limit 20. Flag 0x03 = two literals then copies.
        // Literals 00/FF, offset 1 x17 overlapping copy, zero offset,
        // offset 4095 past the start, then a copy cut off at the limit;
        // the last two bytes arrive after completion and are ignored.
        set_output_length(CNT_W'(20));
        queue_byte(8'h03, 1'b1);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h1F, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hF0, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h20, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h55, 1'b0);
        queue_byte(8'hAA, 1'b0);

        // zero length: a new stream is done before it starts
        set_output_length('0);
        queue_byte(8'h01, 1'b1);
        queue_byte(8'h77, 1'b0);

        // full-scale length: copy on an empty stream, then a restart
        // in the middle of a flag group
        set_output_length('1);
        queue_byte(8'hFE, 1'b1);
        queue_byte(8'h10, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h80, 1'b1);
        queue_byte(8'h42, 1'b0);
        gen_aligned = 0;

        // Random phases: new limit each phase, then a stream continued or
        // restarted, or a run of noise.
        for (int phase = 0; phase < MAX_PHASES
             && live_items + stim_q.size() < ITEM_TARGET; phase++) begin
            r = $urandom_range(0, 99);
            if (r < 4)       out_len = '0;
            else if (r < 10) out_len = CNT_W'(1);
            else if (r < 25) out_len = CNT_W'($urandom_range(2, 64));
            else if (r < 45) out_len = CNT_W'($urandom_range(65, 2000));
            else if (r < 70) out_len = '1;
            else             out_len = CNT_W'($urandom);
            set_output_length(out_len);

            fresh = !gen_aligned || sb.stream_done || ($urandom_range(0, 99) < 30);
            if ($urandom_range(0, 99) < 12) begin
                repeat ($urandom_range(8, 20))
                    queue_byte(8'($urandom), ($urandom_range(0, 9) == 0));
                gen_aligned = 0;
            end else begin
                n_groups = $urandom_range(2, 5);
                for (int g = 0; g < n_groups; g++) begin
                    if (fresh) begin
                        gen_count   = 0;
                        gen_aligned = 1;
                    end
                    broken = ($urandom_range(0, 9) == 0);
                    gen_group(fresh, broken);
                    fresh = broken;
                end
            end
        end

        wait_idle();
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
